FILE: hw/rtl/asa_pkg.sv
package asa_pkg;

	// Request opcodes.
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_CAP   = 2'd1;
	localparam logic [1:0] REG_ALIGN = 2'd2;

	// Field widths.
	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 25;
	localparam int ALIGN_W = 9;
	localparam int PAD_W   = 8;
	localparam int CUR_W   = ADDR_W + 1;
	localparam int STEP_W  = $clog2(CUR_W + 1);

	// Widths of the stream payloads, rounded up to whole bytes.
	localparam int IN_W  = ((2 + 2 * SIZE_W + 7) / 8) * 8;
	localparam int OUT_W = ((ADDR_W + 2 * SIZE_W + 2 + 7) / 8) * 8;

	// Reset values of the configuration registers.
	localparam logic [SIZE_W-1:0]  CAP_RESET   = 25'd65536;
	localparam logic [ALIGN_W-1:0] ALIGN_RESET = 9'd16;
	localparam logic [ALIGN_W-1:0] ALIGN_MAX   = 9'd256;

	// Status of the remainder unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hw/rtl/aligned_stack_allocator.sv
// Stack allocator with alignment padding. Requests (allocate, free, reallocate,
// clear) are handled one at a time; each returns one result with the granted
// address, size, status and the offset in use afterwards. The padding of the
// 33-bit address is found by a serial remainder unit that takes 33 steps for any
// alignment from 1 to 256. An allocate passes the space and depth checks, then
// waits for the remainder unit; a reallocate runs the free check first, and a
// clear goes straight to the remainder unit. A free needs no division, because
// the pad of the top block already sits on the pad stack memory output. A request
// that fails its checks goes straight to the result staging. A stalled receiver
// holds the result back. Errors leave the state unchanged.
// Configuration writes take effect on the next request; new base and alignment
// set the start offset at the next clear.
module aligned_stack_allocator #(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port.
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_wdata,
	// Request stream.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode[1:0], request_size[26:2], old_size[51:27], zero fill up to 55.
	input  logic [asa_pkg::IN_W-1:0]  s_tdata,
	// Result stream.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// block_address[31:0], block_size[56:32], status[58:57], used_bytes[83:59],
	// zero fill up to 87.
	output logic [asa_pkg::OUT_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = $clog2(MAX_BLOCKS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE,
		S_ALLOC,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [asa_pkg::ADDR_W-1:0]  base_q;
	logic [asa_pkg::SIZE_W-1:0]  cap_q;
	logic [asa_pkg::ALIGN_W-1:0] align_q;
	logic [asa_pkg::ALIGN_W-1:0] align_eff;

	// Architectural state.
	logic [asa_pkg::SIZE_W-1:0] top_q;
	logic [CNT_W-1:0]           count_q;

	// Request and working registers.
	logic [1:0]                 op_q;
	logic [asa_pkg::SIZE_W-1:0] req_q;
	logic [asa_pkg::SIZE_W-1:0] old_q;
	logic [asa_pkg::SIZE_W-1:0] off_q;
	logic [CNT_W-1:0]           wcnt_q;
	logic [asa_pkg::CUR_W-1:0]  cur_q;
	logic                       div_start_q;

	// Result staging.
	logic [asa_pkg::ADDR_W-1:0] res_addr_q;
	logic [asa_pkg::SIZE_W-1:0] res_size_q;
	logic [1:0]                 res_stat_q;
	logic                       m_tvalid_q;
	logic [asa_pkg::OUT_W-1:0]  m_tdata_q;

	// Pad stack memory.
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [asa_pkg::PAD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]          ram_raddr;
	logic [asa_pkg::PAD_W-1:0] top_pad;

	// Remainder unit.
	asa_pkg::div_stat_t        div_stat;
	logic [asa_pkg::PAD_W-1:0] div_rem;

	// Combinational datapath.
	logic [asa_pkg::SIZE_W:0]   free_need;
	logic                       free_bad;
	logic [asa_pkg::SIZE_W-1:0] free_room;
	logic [asa_pkg::SIZE_W-1:0] free_off;
	logic [asa_pkg::SIZE_W+1:0] space_need;
	logic                       space_bad;
	logic [asa_pkg::PAD_W-1:0]  pad;
	logic [asa_pkg::ALIGN_W-1:0] pad_diff;
	logic [asa_pkg::SIZE_W-1:0] alloc_off;
	logic [asa_pkg::ADDR_W-1:0] alloc_addr;
	logic                       s_fire;

	// Alignment of zero acts as one, above 256 as 256.
	always_comb begin
		if (align_q == '0) begin
			align_eff = asa_pkg::ALIGN_W'(1);
		end else if (align_q > asa_pkg::ALIGN_MAX) begin
			align_eff = asa_pkg::ALIGN_MAX;
		end else begin
			align_eff = align_q;
		end
	end

	// Free check against the pad of the top block.
	always_comb begin
		free_need = {1'b0, old_q} + asa_pkg::SIZE_W'(top_pad) + 1'b1;
		free_room = top_q - asa_pkg::SIZE_W'(top_pad) - 1'b1;
		free_off  = free_room - old_q;
		free_bad  = (count_q == '0) || ({1'b0, top_q} < free_need);
	end

	// Conservative space check that reserves a whole alignment.
	always_comb begin
		space_need = {2'b00, off_q} + {{(asa_pkg::SIZE_W + 2 - asa_pkg::ALIGN_W){1'b0}}, align_eff}
			+ {2'b00, req_q};
		space_bad  = space_need > {2'b00, cap_q};
	end

	// Pad from the remainder, then the aligned address and the new offset.
	always_comb begin
		pad_diff   = align_eff - {1'b0, div_rem};
		pad        = (div_rem == '0) ? '0 : pad_diff[asa_pkg::PAD_W-1:0];
		alloc_addr = cur_q[asa_pkg::ADDR_W-1:0] + asa_pkg::ADDR_W'(pad);
		alloc_off  = off_q + asa_pkg::SIZE_W'(pad) + req_q + 1'b1;
	end

	assign s_tready  = (state_q == S_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign ram_raddr = IDX_W'(count_q - 1'b1);
	assign ram_we    = (state_q == S_DIV) && div_stat.done && (op_q != asa_pkg::OP_CLEAR);
	assign ram_waddr = IDX_W'(wcnt_q);
	assign ram_wdata = pad;

	asa_ram #(
		.WIDTH(asa_pkg::PAD_W),
		.DEPTH(MAX_BLOCKS)
	) u_pad_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (top_pad)
	);

	asa_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (cur_q),
		.divisor   (align_eff),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			cap_q   <= asa_pkg::CAP_RESET;
			align_q <= asa_pkg::ALIGN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				asa_pkg::REG_BASE:  base_q  <= cfg_wdata;
				asa_pkg::REG_CAP:   cap_q   <= cfg_wdata[asa_pkg::SIZE_W-1:0];
				asa_pkg::REG_ALIGN: align_q <= cfg_wdata[asa_pkg::ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, architectural state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			count_q     <= '0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			op_q        <= asa_pkg::OP_ALLOC;
		end else begin
			div_start_q <= 1'b0;
			// The staging state sets valid itself when it hands over a new result.
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						op_q   <= s_tdata[1:0];
						off_q  <= top_q;
						wcnt_q <= count_q;
						case (s_tdata[1:0])
							asa_pkg::OP_ALLOC: state_q <= S_ALLOC;
							asa_pkg::OP_CLEAR: begin
								cur_q       <= {1'b0, base_q};
								div_start_q <= 1'b1;
								state_q     <= S_DIV;
							end
							default: state_q <= S_FREE;
						endcase
					end
				end
				S_FREE: begin
					if (free_bad) begin
						res_stat_q <= asa_pkg::STAT_EMPTY;
						res_addr_q <= '0;
						res_size_q <= '0;
						state_q    <= S_OUT;
					end else if (op_q == asa_pkg::OP_FREE) begin
						top_q      <= free_off;
						count_q    <= count_q - 1'b1;
						res_stat_q <= asa_pkg::STAT_OK;
						res_addr_q <= '0;
						res_size_q <= '0;
						state_q    <= S_OUT;
					end else begin
						off_q   <= free_off;
						wcnt_q  <= count_q - 1'b1;
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					res_addr_q <= '0;
					res_size_q <= '0;
					if (space_bad) begin
						res_stat_q <= asa_pkg::STAT_NO_SPACE;
						state_q    <= S_OUT;
					end else if (wcnt_q >= CNT_W'(MAX_BLOCKS)) begin
						res_stat_q <= asa_pkg::STAT_FULL;
						state_q    <= S_OUT;
					end else begin
						cur_q       <= {1'b0, base_q} + asa_pkg::CUR_W'(off_q);
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						res_stat_q <= asa_pkg::STAT_OK;
						if (op_q == asa_pkg::OP_CLEAR) begin
							top_q      <= asa_pkg::SIZE_W'(pad);
							count_q    <= '0;
							res_addr_q <= '0;
							res_size_q <= '0;
						end else begin
							top_q      <= alloc_off;
							count_q    <= wcnt_q + 1'b1;
							res_addr_q <= alloc_addr;
							res_size_q <= req_q;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload and result data.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_q <= s_tdata[26:2];
			old_q <= s_tdata[51:27];
		end
		if ((state_q == S_OUT) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {{(asa_pkg::OUT_W - asa_pkg::ADDR_W - 2 * asa_pkg::SIZE_W - 2){1'b0}},
				top_q, res_stat_q, res_size_q, res_addr_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// The live block count never passes the pad stack depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("pad stack count out of range");
	// An accepted request blocks the input until its result is staged.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("request taken while another is in progress");
	// The remainder unit only finishes while the sequencer waits for it.
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("remainder finished outside its wait state");
	// While the sequencer waits, the remainder unit is starting, stepping or done.
	a_div_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_start_q || div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle remainder unit");
	// The pad stack is only written while it has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (wcnt_q < CNT_W'(MAX_BLOCKS)))
		else $error("pad stack written past its depth");
`endif

endmodule

FILE: hw/rtl/asa_ram.sv
module asa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: hw/rtl/asa_mod.sv
module asa_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [asa_pkg::CUR_W-1:0]      dividend,
	input  logic [asa_pkg::ALIGN_W-1:0]    divisor,
	output asa_pkg::div_stat_t             stat,
	output logic [asa_pkg::PAD_W-1:0]      remainder
);

	logic [asa_pkg::CUR_W-1:0]   dvd_q;
	logic [asa_pkg::PAD_W-1:0]   rem_q;
	logic [asa_pkg::STEP_W-1:0]  cnt_q;
	logic                        done_q;
	logic [asa_pkg::ALIGN_W-1:0] trial;
	logic [asa_pkg::ALIGN_W-1:0] diff;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[asa_pkg::CUR_W-1]};
		diff  = trial - divisor;
	end

	// Step counter, dividend shifter and partial remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= asa_pkg::STEP_W'(asa_pkg::CUR_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == asa_pkg::STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[asa_pkg::CUR_W-2:0], 1'b0};
			if (trial >= divisor) begin
				rem_q <= diff[asa_pkg::PAD_W-1:0];
			end else begin
				rem_q <= trial[asa_pkg::PAD_W-1:0];
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	// A finished division takes the full number of steps after its start.
	a_done_after_steps: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(asa_pkg::CUR_W + 1) done_q)
		else $error("remainder unit finished at the wrong step");
	// A finished remainder is below the divisor while the divisor is held.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && $stable(divisor)) |-> ({1'b0, rem_q} < divisor))
		else $error("remainder not reduced below divisor");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;

	localparam int MAX_BLOCKS = 64;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// Index with no register behind it; writes to it must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [asa_pkg::ADDR_W-1:0] block_addr;
		logic [asa_pkg::SIZE_W-1:0] block_len;
		logic [1:0]                 status;
		logic [asa_pkg::SIZE_W-1:0] used;
	} alloc_result_t;

	// Tracks the allocator state, predicts each result and checks the results in order.
	class alloc_scoreboard;
		logic [asa_pkg::ADDR_W-1:0]  base_addr;
		logic [asa_pkg::SIZE_W-1:0]  region_cap;
		logic [asa_pkg::ALIGN_W-1:0] align_cfg;
		longint unsigned             offset;
		logic [asa_pkg::PAD_W-1:0]   pads [MAX_BLOCKS];
		logic [asa_pkg::SIZE_W-1:0]  live_size [MAX_BLOCKS];
		int unsigned                 depth;
		alloc_result_t               pending_results [$];
		int unsigned                 fail_count;

		function new();
			base_addr = '0;
			region_cap = asa_pkg::CAP_RESET;
			align_cfg = asa_pkg::ALIGN_RESET;
			depth = 0;
			fail_count = 0;
			offset = pad_of(0);
		endfunction

		// Alignment in force: zero acts as one, anything above 256 as 256.
		function longint unsigned align_eff();
			if (align_cfg == 0)
				return 1;
			if (align_cfg > asa_pkg::ALIGN_MAX)
				return 256;
			return 64'(align_cfg);
		endfunction

		function longint unsigned pad_of(longint unsigned addr);
			longint unsigned a;
			a = align_eff();
			return (a - addr % a) % a;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
			asa_pkg::REG_BASE: base_addr = value;
			asa_pkg::REG_CAP: region_cap = value[asa_pkg::SIZE_W-1:0];
			asa_pkg::REG_ALIGN: align_cfg = value[asa_pkg::ALIGN_W-1:0];
			default: ;
			endcase
		endfunction

		// Size of the block on top of the stack, used to build well-formed frees.
		function logic [asa_pkg::SIZE_W-1:0] top_size();
			return (depth > 0) ? live_size[depth-1] : '0;
		endfunction

		// Places a block at offset off with count blocks live; the space check
		// reserves a whole alignment and comes before the stack depth check.
		function logic [1:0] try_place(longint unsigned off, int unsigned count,
				longint unsigned len, output longint unsigned new_off,
				output logic [asa_pkg::PAD_W-1:0] pad,
				output logic [asa_pkg::ADDR_W-1:0] addr);
			longint unsigned cur, p;
			new_off = off;
			pad = '0;
			addr = '0;
			if (off + align_eff() + len > 64'(region_cap))
				return asa_pkg::STAT_NO_SPACE;
			if (count >= MAX_BLOCKS)
				return asa_pkg::STAT_FULL;
			cur = longint'(base_addr) + off;
			p = pad_of(cur);
			pad = p[asa_pkg::PAD_W-1:0];
			addr = asa_pkg::ADDR_W'(cur + p);
			new_off = off + p + len + 1;
			return asa_pkg::STAT_OK;
		endfunction

		// Releases the top block; fails on an empty stack or an oversized length.
		function logic [1:0] try_release(longint unsigned len, output longint unsigned new_off);
			longint unsigned p, room;
			new_off = offset;
			if (depth == 0)
				return asa_pkg::STAT_EMPTY;
			p = 64'(pads[depth-1]);
			if (offset < p + 1)
				return asa_pkg::STAT_EMPTY;
			room = offset - 1 - p;
			if (len > room)
				return asa_pkg::STAT_EMPTY;
			new_off = room - len;
			return asa_pkg::STAT_OK;
		endfunction

		// Applies one accepted request and queues the result it must produce.
		function void note_request(logic [1:0] op, logic [asa_pkg::SIZE_W-1:0] req,
				logic [asa_pkg::SIZE_W-1:0] old);
			alloc_result_t r;
			longint unsigned off, freed;
			logic [asa_pkg::PAD_W-1:0] pad;
			logic [asa_pkg::ADDR_W-1:0] addr;
			logic [1:0] st;
			r = '0;
			st = asa_pkg::STAT_OK;
			case (op)
			asa_pkg::OP_ALLOC: begin
				st = try_place(offset, depth, 64'(req), off, pad, addr);
				if (st == asa_pkg::STAT_OK) begin
					pads[depth] = pad;
					live_size[depth] = req;
					depth++;
					offset = off;
					r.block_addr = addr;
					r.block_len = req;
				end
			end
			asa_pkg::OP_FREE: begin
				st = try_release(64'(old), off);
				if (st == asa_pkg::STAT_OK) begin
					depth--;
					offset = off;
				end
			end
			asa_pkg::OP_REALLOC: begin
				// A failed allocate half leaves the freed block in place.
				st = try_release(64'(old), freed);
				if (st == asa_pkg::STAT_OK) begin
					st = try_place(freed, depth - 1, 64'(req), off, pad, addr);
					if (st == asa_pkg::STAT_OK) begin
						pads[depth-1] = pad;
						live_size[depth-1] = req;
						offset = off;
						r.block_addr = addr;
						r.block_len = req;
					end
				end
			end
			default: begin
				depth = 0;
				offset = pad_of(64'(base_addr));
			end
			endcase
			r.status = st;
			r.used = offset[asa_pkg::SIZE_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				fail_count++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		// Compares one accepted result with the oldest expectation.
		function void check_result(logic [asa_pkg::OUT_W-1:0] data);
			alloc_result_t got, want;
			got.block_addr = data[31:0];
			got.block_len = data[56:32];
			got.status = data[58:57];
			got.used = data[83:59];
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("block_address", want.block_addr, got.block_addr);
			compare_field("block_size", 32'(want.block_len), 32'(got.block_len));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("used_bytes", 32'(want.used), 32'(got.used));
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [1:0]                cfg_index = '0;
	logic [31:0]               cfg_wdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [asa_pkg::IN_W-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [asa_pkg::OUT_W-1:0] m_tdata;

	alloc_scoreboard sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;

	aligned_stack_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random, changing its ready at the falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// Every result transfer is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void set_idle(idle_mode_t mode);
		case (mode)
		IDLE_SEND: begin
			send_idle_pct = 70;
			recv_stall_pct = 0;
		end
		IDLE_RECV: begin
			send_idle_pct = 0;
			recv_stall_pct = 70;
		end
		IDLE_BOTH: begin
			send_idle_pct = 22;
			recv_stall_pct = 22;
		end
		default: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		endcase
	endfunction

	// Sends one request, called and returning at a falling edge. Valid stays high
	// after the transfer so back-to-back requests need no second assignment.
	task automatic send_request(logic [1:0] op, logic [asa_pkg::SIZE_W-1:0] req,
			logic [asa_pkg::SIZE_W-1:0] old);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(asa_pkg::IN_W - 2 - 2 * asa_pkg::SIZE_W){1'b0}}, old, req, op};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(op, req, old);
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	// Writes all registers, with junk in the unused upper bits and to the unused index.
	task automatic configure_region(logic [asa_pkg::ADDR_W-1:0] base,
			logic [asa_pkg::SIZE_W-1:0] cap, logic [asa_pkg::ALIGN_W-1:0] align);
		write_reg(asa_pkg::REG_BASE, base);
		write_reg(asa_pkg::REG_CAP, {7'($urandom), cap});
		write_reg(asa_pkg::REG_ALIGN, {23'($urandom), align});
		write_reg(REG_UNUSED, $urandom);
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly well-formed requests: frees name the top block, with some broken ones.
	task automatic random_request(int unsigned alloc_pct, int unsigned size_max);
		int unsigned pick, rest;
		logic [1:0] op;
		logic [asa_pkg::SIZE_W-1:0] req, old;
		pick = $urandom_range(99, 0);
		rest = 100 - alloc_pct;
		req = asa_pkg::SIZE_W'($urandom_range(size_max, 0));
		if ($urandom_range(15, 0) == 0)
			req = asa_pkg::SIZE_W'($urandom);
		old = (sb.depth > 0) ? sb.top_size() :
			asa_pkg::SIZE_W'($urandom_range(size_max, 0));
		if ($urandom_range(9, 0) == 0)
			old = old + asa_pkg::SIZE_W'($urandom_range(3, 1));
		if ($urandom_range(31, 0) == 0)
			old = asa_pkg::SIZE_W'($urandom);
		if (pick < alloc_pct)
			op = asa_pkg::OP_ALLOC;
		else if (pick < alloc_pct + rest * 6 / 10)
			op = asa_pkg::OP_FREE;
		else if (pick < alloc_pct + rest * 9 / 10)
			op = asa_pkg::OP_REALLOC;
		else
			op = asa_pkg::OP_CLEAR;
		send_request(op, req, old);
	endtask

	task automatic run_phase(logic [asa_pkg::ADDR_W-1:0] base, logic [asa_pkg::SIZE_W-1:0] cap,
			logic [asa_pkg::ALIGN_W-1:0] align, idle_mode_t mode, int unsigned alloc_pct,
			int unsigned size_max, int unsigned count);
		configure_region(base, cap, align);
		set_idle(mode);
		repeat (count) random_request(alloc_pct, size_max);
		drain_results();
	endtask

	initial begin
		int unsigned rand_cap;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests with the reset settings: grants, frees down to empty,
		// free of an empty stack, oversized free, reallocate and its failed form.
		set_idle(IDLE_NONE);
		send_request(asa_pkg::OP_ALLOC, 0, 0);
		send_request(asa_pkg::OP_ALLOC, 100, 0);
		send_request(asa_pkg::OP_FREE, 0, 100);
		send_request(asa_pkg::OP_FREE, 0, 0);
		send_request(asa_pkg::OP_FREE, 0, 0);
		send_request(asa_pkg::OP_REALLOC, 10, 0);
		send_request(asa_pkg::OP_ALLOC, 50, 0);
		send_request(asa_pkg::OP_FREE, 0, 51);
		send_request(asa_pkg::OP_REALLOC, 200, 50);
		send_request(asa_pkg::OP_REALLOC, 25'h100_0000, 200);
		send_request(asa_pkg::OP_ALLOC, 25'h1FF_FFFF, 0);
		send_request(asa_pkg::OP_FREE, 0, 25'h1FF_FFFF);
		send_request(asa_pkg::OP_CLEAR, 25'h1FF_FFFF, 25'h1FF_FFFF);
		drain_results();

		// Zero capacity and zero alignment at the top of the address space.
		configure_region(32'hFFFF_FFFF, 0, 0);
		send_request(asa_pkg::OP_ALLOC, 0, 0);
		send_request(asa_pkg::OP_CLEAR, 0, 0);
		send_request(asa_pkg::OP_ALLOC, 1, 0);
		drain_results();

		// Oversized alignment and the widest capacity; the grant wraps past 2^32.
		configure_region(32'hFFFF_FFF1, 25'h1FF_FFFF, 9'd511);
		send_request(asa_pkg::OP_CLEAR, 0, 0);
		send_request(asa_pkg::OP_ALLOC, 25'h100_0000, 0);
		send_request(asa_pkg::OP_ALLOC, 3, 0);
		send_request(asa_pkg::OP_REALLOC, 0, 3);
		send_request(asa_pkg::OP_FREE, 0, 0);
		send_request(asa_pkg::OP_FREE, 0, 25'h100_0000);
		send_request(asa_pkg::OP_FREE, 0, 0);
		drain_results();

		// Random phases over several region settings and idling patterns.
		run_phase($urandom, 65536, 16, IDLE_NONE, 50, 600, 150);
		run_phase(32'hFFFF_FF00, 25'h1FF_FFFF, 256, IDLE_SEND, 55, 300000, 150);
		run_phase($urandom, 1000, 7, IDLE_RECV, 55, 120, 150);
		run_phase(0, 65536, 1, IDLE_BOTH, 80, 20, 150);
		run_phase(32'hFFFF_FFFF, 0, 0, IDLE_NONE, 50, 50, 50);
		rand_cap = $urandom_range(25'h1FF_FFFF, 1);
		run_phase($urandom, asa_pkg::SIZE_W'(rand_cap), 9'd511, IDLE_SEND, 55,
			rand_cap / 40 + 1, 150);
		run_phase($urandom, 4096, asa_pkg::ALIGN_W'($urandom_range(300, 1)), IDLE_RECV,
			75, 40, 150);
		rand_cap = $urandom_range(100000, 16);
		run_phase($urandom, asa_pkg::SIZE_W'(rand_cap),
			asa_pkg::ALIGN_W'($urandom_range(511, 0)), IDLE_BOTH, 55,
			rand_cap / 30 + 1, 180);

		repeat (40) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
